/* rtl/gcd_pkg.sv */
// gcd_pkg: shared types and constants of the graph cycle detect unit
// used by gcd_front, gcd_queue, gcd_search and graph_cycle_detect_unit
// no dependencies
`default_nettype none

package gcd_pkg;

    localparam int ROW_IDX_W   = 6;
    localparam int ROW_BITS_W  = 64;
    localparam int VCOUNT_W    = 7;
    localparam int DEPTH_W     = 7;
    // queue between front and back, kept at a power of two
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

    // one classified row beat
    typedef struct packed {
        logic                  start;
        logic                  store_en;
        logic [ROW_BITS_W-1:0] row_bits;
        logic [ROW_IDX_W-1:0]  row_idx;
    } gcd_entry_t;

    // search engine status seen by the top level
    typedef struct packed {
        logic               busy;
        logic [DEPTH_W-1:0] depth;
    } gcd_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_SCAN,
        ST_POP
    } gcd_state_t;

endpackage

`default_nettype wire

/* rtl/gcd_front.sv */
// gcd_front: input stage, registers each row beat and classifies it
// depends on gcd_pkg
`default_nettype none

module gcd_front #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [gcd_pkg::ROW_IDX_W-1:0]  in_row_idx,
    input  wire logic [gcd_pkg::ROW_BITS_W-1:0] in_row_bits,
    input  wire logic                        in_last,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output gcd_pkg::gcd_entry_t              out_entry
);

    localparam logic [gcd_pkg::ROW_IDX_W:0] MAXV = (gcd_pkg::ROW_IDX_W + 1)'(MAX_VERTICES);

    logic                valid_reg;
    logic                valid_next;
    gcd_pkg::gcd_entry_t entry_reg;
    gcd_pkg::gcd_entry_t entry_next;
    logic                accept;

    // hold slot frees when empty or when the queue takes it
    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // classify: rows beyond the store are dropped, last row starts a search
    always_comb
    begin
        entry_next          = entry_reg;
        valid_next          = valid_reg && !out_ready;
        if (accept)
        begin
            entry_next.row_idx  = in_row_idx;
            entry_next.row_bits = in_row_bits;
            entry_next.store_en = ({1'b0, in_row_idx} < MAXV);
            entry_next.start    = in_last;
            valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign out_valid = valid_reg;
    assign out_entry = entry_reg;

endmodule

`default_nettype wire

/* rtl/gcd_queue.sv */
// gcd_queue: short fifo of classified row beats between front and back
// depends on gcd_pkg
`default_nettype none

module gcd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire gcd_pkg::gcd_entry_t in_entry,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output gcd_pkg::gcd_entry_t      out_entry
);

    localparam int AW = (gcd_pkg::QUEUE_DEPTH > 1) ? $clog2(gcd_pkg::QUEUE_DEPTH) : 1;
    localparam logic [AW:0] FULL = (AW + 1)'(gcd_pkg::QUEUE_DEPTH);

    gcd_pkg::gcd_entry_t slots [gcd_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW:0]   count_reg;
    logic [AW:0]   count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != FULL);
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_entry = slots[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

`default_nettype wire

/* rtl/gcd_search.sv */
// gcd_search: back end, adjacency store, depth-first search engine and result register
// depends on gcd_pkg
`default_nettype none

module gcd_search #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [gcd_pkg::VCOUNT_W-1:0]  vertex_count,
    input  wire logic                          q_valid,
    output logic                               q_ready,
    input  wire gcd_pkg::gcd_entry_t           q_entry,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic                               res_cycle,
    output gcd_pkg::gcd_status_t               status
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = VW + 1;
    localparam int SW = VW + CW + VW + 1;
    localparam logic [MAX_VERTICES-1:0] BIT0 = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

    // adjacency store and its registered read
    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] adj_q;
    logic                    adj_we;
    logic                    adj_re;
    logic [VW-1:0]           adj_raddr;

    // stack of entries below the top, registered read
    logic [SW-1:0] stk_mem [MAX_VERTICES];
    logic [SW-1:0] stk_q;
    logic [SW-1:0] stk_wdata;
    logic          stk_we;
    logic          stk_re;
    logic [VW-1:0] stk_waddr;
    logic [VW-1:0] stk_raddr;

    gcd_pkg::gcd_state_t     state_reg;
    gcd_pkg::gcd_state_t     state_next;
    logic [VW-1:0]           top_vertex_reg;
    logic [VW-1:0]           top_vertex_next;
    logic [CW-1:0]           top_scan_reg;
    logic [CW-1:0]           top_scan_next;
    logic [VW-1:0]           top_parent_reg;
    logic [VW-1:0]           top_parent_next;
    logic                    top_pvalid_reg;
    logic                    top_pvalid_next;
    logic [CW-1:0]           depth_reg;
    logic [CW-1:0]           depth_next;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] visited_next;
    logic                    res_valid_reg;
    logic                    res_valid_next;
    logic                    res_cycle_reg;
    logic                    res_cycle_next;

    logic [CW-1:0]           n_act;
    logic [MAX_VERTICES-1:0] colmask;
    logic [MAX_VERTICES-1:0] scanmask;
    logic [VW:0]             nb_enc;
    logic [VW:0]             root_enc;
    logic [VW-1:0]           nb;
    logic [VW-1:0]           root;
    logic [CW-1:0]           depth_m1;
    logic [CW-1:0]           depth_m2;
    logic [CW-1:0]           nb_plus1;

    // lowest set bit, found flag on top
    function automatic logic [VW:0] lowest_set(input logic [MAX_VERTICES-1:0] v);
        logic [VW:0] r;
        r = '0;
        for (int j = MAX_VERTICES - 1; j >= 0; j--)
        begin
            if (v[j])
            begin
                r = {1'b1, VW'(j)};
            end
        end
        return r;
    endfunction

    // vertex count saturated to the store size
    always_comb
    begin
        if (vertex_count > gcd_pkg::VCOUNT_W'(MAX_VERTICES))
        begin
            n_act = CW'(MAX_VERTICES);
        end
        else
        begin
            n_act = vertex_count[CW-1:0];
        end
    end

    // column window and scan window of the top entry
    always_comb
    begin
        for (int j = 0; j < MAX_VERTICES; j++)
        begin
            colmask[j]  = (CW'(j) < n_act);
            scanmask[j] = (CW'(j) >= top_scan_reg);
        end
    end

    assign nb_enc   = lowest_set(adj_q & colmask & scanmask);
    assign root_enc = lowest_set(~visited_reg & colmask);
    assign nb       = nb_enc[VW-1:0];
    assign root     = root_enc[VW-1:0];
    assign nb_plus1 = {1'b0, nb} + CW'(1);
    assign depth_m1 = depth_reg - CW'(1);
    assign depth_m2 = depth_reg - CW'(2);

    // search sequencer
    always_comb
    begin
        state_next      = state_reg;
        top_vertex_next = top_vertex_reg;
        top_scan_next   = top_scan_reg;
        top_parent_next = top_parent_reg;
        top_pvalid_next = top_pvalid_reg;
        depth_next      = depth_reg;
        visited_next    = visited_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_cycle_next  = res_cycle_reg;
        q_ready         = 1'b0;
        adj_we          = 1'b0;
        adj_re          = 1'b0;
        adj_raddr       = top_vertex_reg;
        stk_we          = 1'b0;
        stk_re          = 1'b0;
        stk_waddr       = depth_m1[VW-1:0];
        stk_raddr       = depth_m2[VW-1:0];
        stk_wdata       = {top_vertex_reg, nb_plus1, top_parent_reg, top_pvalid_reg};
        case (state_reg)
            gcd_pkg::ST_IDLE:
            begin
                // a search starts only with the result register free
                if (q_valid && (!q_entry.start || !res_valid_reg))
                begin
                    q_ready = 1'b1;
                    adj_we  = q_entry.store_en;
                    if (q_entry.start)
                    begin
                        visited_next = '0;
                        depth_next   = '0;
                        state_next   = gcd_pkg::ST_ROOT;
                    end
                end
            end
            gcd_pkg::ST_ROOT:
            begin
                // lowest unvisited vertex is the next root
                if (root_enc[VW])
                begin
                    top_vertex_next = root;
                    top_scan_next   = '0;
                    top_parent_next = '0;
                    top_pvalid_next = 1'b0;
                    depth_next      = CW'(1);
                    visited_next    = visited_reg | (BIT0 << root);
                    adj_re          = 1'b1;
                    adj_raddr       = root;
                    state_next      = gcd_pkg::ST_SCAN;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    res_cycle_next = 1'b0;
                    state_next     = gcd_pkg::ST_IDLE;
                end
            end
            gcd_pkg::ST_SCAN:
            begin
                if (!nb_enc[VW])
                begin
                    // no neighbor left: pop
                    if (depth_reg == CW'(1))
                    begin
                        depth_next = '0;
                        state_next = gcd_pkg::ST_ROOT;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        depth_next = depth_m1;
                        state_next = gcd_pkg::ST_POP;
                    end
                end
                else if (!visited_reg[nb])
                begin
                    // descend into an unvisited neighbor
                    stk_we          = 1'b1;
                    top_vertex_next = nb;
                    top_scan_next   = '0;
                    top_parent_next = top_vertex_reg;
                    top_pvalid_next = 1'b1;
                    depth_next      = depth_reg + CW'(1);
                    visited_next    = visited_reg | (BIT0 << nb);
                    adj_re          = 1'b1;
                    adj_raddr       = nb;
                end
                else if (!top_pvalid_reg || (top_parent_reg != nb))
                begin
                    // visited vertex other than the parent closes a cycle
                    depth_next     = '0;
                    res_valid_next = 1'b1;
                    res_cycle_next = 1'b1;
                    state_next     = gcd_pkg::ST_IDLE;
                end
                else
                begin
                    top_scan_next = nb_plus1;
                end
            end
            gcd_pkg::ST_POP:
            begin
                // resume the entry below and refetch its row
                top_vertex_next = stk_q[SW-1 -: VW];
                top_scan_next   = stk_q[VW+1 +: CW];
                top_parent_next = stk_q[1 +: VW];
                top_pvalid_next = stk_q[0];
                adj_re          = 1'b1;
                adj_raddr       = stk_q[SW-1 -: VW];
                state_next      = gcd_pkg::ST_SCAN;
            end
            default:
            begin
                state_next = gcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcd_pkg::ST_IDLE;
            depth_reg     <= '0;
            visited_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            visited_reg   <= visited_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // top entry and result payload
    always_ff @(posedge clk)
    begin
        top_vertex_reg <= top_vertex_next;
        top_scan_reg   <= top_scan_next;
        top_parent_reg <= top_parent_next;
        top_pvalid_reg <= top_pvalid_next;
        res_cycle_reg  <= res_cycle_next;
    end

    // adjacency store
    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[q_entry.row_idx[VW-1:0]] <= q_entry.row_bits[MAX_VERTICES-1:0];
        end
        if (adj_re)
        begin
            adj_q <= adj_mem[adj_raddr];
        end
    end

    // stack store
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_q <= stk_mem[stk_raddr];
        end
    end

    assign res_valid    = res_valid_reg;
    assign res_cycle    = res_cycle_reg;
    assign status.busy  = (state_reg != gcd_pkg::ST_IDLE);
    assign status.depth = gcd_pkg::DEPTH_W'(depth_reg);

endmodule

`default_nettype wire

/* rtl/graph_cycle_detect_unit.sv */
// graph_cycle_detect_unit: top level, cycle detection in a graph held as an adjacency matrix
// depends on gcd_pkg, gcd_front, gcd_queue, gcd_search
//
// Rows of the adjacency matrix arrive one per input beat and are taken at one beat per
// cycle while the queue has room, through a front register and a two-entry queue into
// the row store. The beat with tlast set stores its row and then starts a depth-first
// search over the first vertex_count vertices (saturated to MAX_VERTICES); one output
// beat carries the cycle flag. The search sequencer picks a root, scans its row
// neighbor by neighbor, pops the last entry of a tree straight back to root selection
// and any other pop through a stack read, then a row read, and closes with a result
// when no root is left; it stops at the first cycle found. While a search runs further
// rows are still accepted until the queue and the front register fill. vertex_count is
// to be written with cfg_wr_en only while the block is idle; the block does not enforce it.

`default_nettype none

module graph_cycle_detect_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // row_index [5:0], row_bits [69:6], zero fill
    input  wire logic        s_axis_tlast,   // last_row
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // has_cycle [0], zero fill
);

    logic [gcd_pkg::VCOUNT_W-1:0] vertex_count_reg;
    logic                         front_valid;
    logic                         front_ready;
    gcd_pkg::gcd_entry_t          front_entry;
    logic                         q_valid;
    logic                         q_ready;
    gcd_pkg::gcd_entry_t          q_entry;
    logic                         res_cycle;
    gcd_pkg::gcd_status_t         status;

    // vertex count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= gcd_pkg::VCOUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    gcd_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_row_idx  (s_axis_tdata[5:0]),
        .in_row_bits (s_axis_tdata[69:6]),
        .in_last     (s_axis_tlast),
        .out_valid   (front_valid),
        .out_ready   (front_ready),
        .out_entry   (front_entry)
    );

    gcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_entry  (front_entry),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_entry (q_entry)
    );

    gcd_search #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_count (vertex_count_reg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_entry      (q_entry),
        .res_valid    (m_axis_tvalid),
        .res_ready    (m_axis_tready),
        .res_cycle    (res_cycle),
        .status       (status)
    );

    assign m_axis_tdata = {7'b0, res_cycle};

`ifndef SYNTH
    // a result never waits while a search is running
    assert property (@(posedge clk) disable iff (!rst_n)
        !(status.busy && m_axis_tvalid))
        else $error("result pending during search");

    // stack depth stays within the vertex store
    assert property (@(posedge clk) disable iff (!rst_n)
        status.depth <= gcd_pkg::DEPTH_W'(MAX_VERTICES))
        else $error("stack depth overflow");

    // a result beat appears only at the end of a search
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(status.busy))
        else $error("result without search");
`endif

endmodule

`default_nettype wire

/* sim/gcd_cycle_checker.sv */
// gcd_cycle_checker: watches the row and flag streams of graph_cycle_detect_unit,
// predicts the cycle flag of every frame and compares it with the output beats
// depends on gcd_pkg

module gcd_cycle_checker #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,
    output int               mismatch_count,
    output int               pending_flags
);

    // shadow copy of the row store and the vertex count register
    logic [gcd_pkg::ROW_BITS_W-1:0] adj_rows [MAX_VERTICES];
    logic [gcd_pkg::VCOUNT_W-1:0]   vertex_limit;
    logic                           cycle_flags_due [$];
    logic                           want_flag;

    task automatic report_mismatch(input string what);
        $display("[%0t] cycle check mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // iterative dfs over the stored rows, roots and neighbors in ascending order
    function automatic logic graph_has_cycle();
        int unsigned                    n;
        logic [gcd_pkg::ROW_BITS_W-1:0] col_mask;
        logic [gcd_pkg::ROW_BITS_W-1:0] seen;
        logic [gcd_pkg::ROW_BITS_W-1:0] row;
        int unsigned                    stk_node [MAX_VERTICES];
        int unsigned                    stk_scan [MAX_VERTICES];
        int unsigned                    stk_up [MAX_VERTICES];
        bit                             stk_up_ok [MAX_VERTICES];
        int                             sp;
        int unsigned                    i;
        bit                             hit;
        n = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
        col_mask = (n >= gcd_pkg::ROW_BITS_W) ? '1 : ((64'd1 << n) - 64'd1);
        seen = '0;
        for (int unsigned root = 0; root < n; root++)
        begin
            if (seen[root])
                continue;
            sp = 1;
            stk_node[0] = root;
            stk_scan[0] = 0;
            stk_up[0] = 0;
            stk_up_ok[0] = 1'b0;
            seen[root] = 1'b1;
            while (sp > 0)
            begin
                row = adj_rows[stk_node[sp-1]] & col_mask;
                i = stk_scan[sp-1];
                hit = 1'b0;
                while (i < n && !hit)
                begin
                    if (row[i])
                        hit = 1'b1;
                    else
                        i++;
                end
                // row exhausted, pop the vertex
                if (!hit)
                begin
                    sp--;
                    continue;
                end
                stk_scan[sp-1] = i + 1;
                if (!seen[i])
                begin
                    stk_node[sp] = i;
                    stk_scan[sp] = 0;
                    stk_up[sp] = stk_node[sp-1];
                    stk_up_ok[sp] = 1'b1;
                    seen[i] = 1'b1;
                    sp++;
                end
                else if (!stk_up_ok[sp-1] || stk_up[sp-1] != i)
                begin
                    // back edge or self-loop
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // track config writes, row beats and flag beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_limit = gcd_pkg::VCOUNT_RESET;
            cycle_flags_due.delete();
            mismatch_count = 0;
            pending_flags <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                vertex_limit = cfg_wr_data;
            // flag beat against the oldest open frame
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (cycle_flags_due.size() == 0)
                begin
                    report_mismatch($sformatf("flag beat %0b with no frame open",
                                              m_axis_tdata[0]));
                end
                else
                begin
                    want_flag = cycle_flags_due.pop_front();
                    if (m_axis_tdata[0] !== want_flag)
                        report_mismatch($sformatf("has_cycle %0b, predicted %0b",
                                                  m_axis_tdata[0], want_flag));
                end
            end
            // row beat: store, and predict on the last row
            if (s_axis_tvalid && s_axis_tready)
            begin
                adj_rows[s_axis_tdata[gcd_pkg::ROW_IDX_W-1:0]] =
                    s_axis_tdata[gcd_pkg::ROW_IDX_W +: gcd_pkg::ROW_BITS_W];
                if (s_axis_tlast)
                    cycle_flags_due.push_back(graph_has_cycle());
            end
            pending_flags <= cycle_flags_due.size();
        end
    end

endmodule

/* sim/graph_cycle_detect_unit_tb.sv */
// graph_cycle_detect_unit_tb: drives adjacency rows and config writes into the
// cycle detect unit under varying stream idling; verdict from gcd_cycle_checker
// depends on gcd_pkg, graph_cycle_detect_unit, gcd_cycle_checker

module graph_cycle_detect_unit_tb;

    localparam int NUM_VERTICES  = 64;
    localparam int ITEM_TARGET   = 1700;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_CYCLES  = 16;
    localparam int SETTLE_CYCLES = 400;

    typedef enum int {
        SHAPE_FOREST,
        SHAPE_FOREST_CHORD,
        SHAPE_ONE_WAY,
        SHAPE_RANDOM
    } graph_shape_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;

    int          mismatch_count;
    int          pending_flags;
    int          src_idle_pct;
    int          sink_idle_pct;
    int          hold_requests;
    int          items_sent;
    longint      cycle_count = 0;
    logic [63:0] frame_rows [NUM_VERTICES];
    logic [63:0] rows_loaded;
    logic [6:0]  vcount_now;

    graph_cycle_detect_unit #(
        .MAX_VERTICES(NUM_VERTICES)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    gcd_cycle_checker #(
        .MAX_VERTICES(NUM_VERTICES)
    ) cycle_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatch_count(mismatch_count),
        .pending_flags (pending_flags)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("graph_cycle_detect_unit regression: fail");
            $finish;
        end
    end

    // flag receiver: random stalls, or a long hold when one is requested
    initial
    begin : flag_sink
        int hold_left;
        int holds_served;
        hold_left = 0;
        holds_served = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_requests != holds_served)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned active_vertices(input logic [6:0] count);
        return (count > NUM_VERTICES) ? NUM_VERTICES : count;
    endfunction

    // one row beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [5:0] idx, input logic [63:0] bits, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, bits, idx};
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        rows_loaded[idx] = 1'b1;
        items_sent++;
    endtask

    // stop offering rows and wait for every open frame's flag
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_flags != 0);
    endtask

    task automatic write_vertex_count(input logic [6:0] value);
        drain_results();
        repeat (QUIET_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        vcount_now = value;
    endtask

    // fill frame_rows[0..n-1] with a graph of the given shape
    task automatic build_graph(input int unsigned n, input graph_shape_t shape);
        int unsigned p;
        int unsigned a;
        int unsigned b;
        logic [63:0] col_mask;
        col_mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        for (int unsigned v = 0; v < n; v++)
            frame_rows[v] = '0;
        if (shape == SHAPE_RANDOM)
        begin
            for (int unsigned v = 0; v < n; v++)
            begin
                frame_rows[v] = rand_word() & rand_word();
                if ($urandom_range(1))
                    frame_rows[v] &= rand_word();
                if ($urandom_range(1))
                    frame_rows[v] &= rand_word();
            end
        end
        else
        begin
            // random forest, one-way edges for the asymmetric shape
            for (int unsigned v = 1; v < n; v++)
            begin
                if ($urandom_range(9) < 8)
                begin
                    p = $urandom_range(v - 1);
                    if (shape != SHAPE_ONE_WAY || $urandom_range(1))
                        frame_rows[v][p] = 1'b1;
                    if (shape != SHAPE_ONE_WAY || $urandom_range(1))
                        frame_rows[p][v] = 1'b1;
                end
            end
            // one extra edge, possibly a self-loop
            if (shape == SHAPE_FOREST_CHORD)
            begin
                a = $urandom_range(n - 1);
                b = $urandom_range(n - 1);
                frame_rows[a][b] = 1'b1;
                frame_rows[b][a] = 1'b1;
            end
        end
        // junk in the columns beyond the vertex count
        if (n < 64 && $urandom_range(1))
        begin
            for (int unsigned v = 0; v < n; v++)
                frame_rows[v] |= rand_word() & ~col_mask;
        end
    endtask

    // a full frame in shuffled or ascending order, a partial rewrite, or one random last beat when n is zero
    task automatic send_frame(input int unsigned n);
        int unsigned order [$];
        int unsigned pick;
        int unsigned tmp;
        logic [63:0] col_mask;
        if (n == 0)
        begin
            send_beat(6'($urandom_range(63)), rand_word(), 1'b1);
            return;
        end
        col_mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        build_graph(n, graph_shape_t'($urandom_range(SHAPE_RANDOM)));
        if (((rows_loaded & col_mask) == col_mask) && $urandom_range(3) == 0)
        begin
            repeat ($urandom_range(n, 1))
                order.push_back($urandom_range(n - 1));
        end
        else
        begin
            for (int unsigned v = 0; v < n; v++)
                order.push_back(v);
            if ($urandom_range(1))
            begin
                for (int k = order.size() - 1; k > 0; k--)
                begin
                    pick = $urandom_range(k);
                    tmp = order[k];
                    order[k] = order[pick];
                    order[pick] = tmp;
                end
            end
        end
        foreach (order[j])
        begin
            // rows outside the vertex range now and then
            if (n < 64 && $urandom_range(7) == 0)
                send_beat(6'($urandom_range(63, n)), rand_word(), 1'b0);
            send_beat(6'(order[j]), frame_rows[order[j]], j == order.size() - 1);
        end
    endtask

    function automatic logic [6:0] pick_vertex_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)
            return 7'd0;
        if (r < 8)
            return 7'($urandom_range(127, 65));
        if (r < 13)
            return 7'd64;
        if (r < 20)
            return 7'($urandom_range(63, 9));
        return 7'($urandom_range(8, 1));
    endfunction

    // random settings and frames until the item count reaches target
    task automatic run_phase(input int src_pct, input int sink_pct, input int target);
        int unsigned n;
        src_idle_pct = src_pct;
        sink_idle_pct <= sink_pct;
        while (items_sent < target)
        begin
            write_vertex_count(pick_vertex_count());
            n = active_vertices(vcount_now);
            repeat ((n >= 32) ? $urandom_range(2, 1) : $urandom_range(10, 3))
                send_frame(n);
        end
    endtask

    // stimulus and verdict
    initial
    begin : row_source
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        sink_idle_pct <= 0;
        hold_requests <= 0;
        src_idle_pct = 23;
        rows_loaded = '0;
        items_sent = 0;
        vcount_now = gcd_pkg::VCOUNT_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        sink_idle_pct <= 70;

        // single vertex: empty row, self-loop, bits beyond the count only, all ones
        write_vertex_count(7'd1);
        send_beat(6'd0, 64'd0, 1'b1);
        send_beat(6'd0, 64'd1, 1'b1);
        send_beat(6'd0, ~64'd1, 1'b1);
        send_beat(6'd0, '1, 1'b1);
        // two vertices: parent edge, one-way edge, self-loop on the second
        write_vertex_count(7'd2);
        send_beat(6'd0, 64'd2, 1'b0);
        send_beat(6'd1, 64'd1, 1'b1);
        send_beat(6'd1, 64'd0, 1'b1);
        send_beat(6'd1, 64'd2, 1'b1);
        // triangle, then the third row replaced by junk beyond the count
        write_vertex_count(7'd3);
        send_beat(6'd0, 64'd6, 1'b0);
        send_beat(6'd1, 64'd5, 1'b0);
        send_beat(6'd2, 64'd3, 1'b1);
        send_beat(6'd2, 64'hFFFF_FFFF_FFFF_FFF8, 1'b1);
        // no vertices
        write_vertex_count(7'd0);
        send_beat(6'd63, '1, 1'b1);
        // count above the maximum saturates: a 64-vertex path, deepest stack
        write_vertex_count(7'd127);
        for (int v = 0; v < NUM_VERTICES; v++)
        begin
            frame_rows[v] = '0;
            if (v > 0)
                frame_rows[v][v-1] = 1'b1;
            if (v < NUM_VERTICES - 1)
                frame_rows[v][v+1] = 1'b1;
            send_beat(6'(v), frame_rows[v], v == NUM_VERTICES - 1);
        end

        run_phase(23, 70, ITEM_TARGET / 3);
        run_phase(70, 23, 2 * ITEM_TARGET / 3);

        // flag receiver held off while frames keep coming, until the input stalls
        src_idle_pct = 0;
        sink_idle_pct <= 0;
        write_vertex_count(7'd4);
        hold_requests <= hold_requests + 1;
        repeat (10) send_frame(4);
        run_phase(0, 0, ITEM_TARGET);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("graph_cycle_detect_unit regression: pass");
        else
            $display("graph_cycle_detect_unit regression: fail");
        $finish;
    end

endmodule
